/* src/bra_pkg.sv */
// Shared types and constants for the bitmap range allocator.
package bra_pkg;

    localparam int BITS      = 1024;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = BITS / WORD_BITS;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int BIDX_W    = $clog2(WORD_BITS);
    localparam int IDX_W     = 11;
    localparam int JIDX_W    = BIDX_W + 1;

    localparam logic [IDX_W-1:0] SIZE_MAX = IDX_W'(BITS);

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_CONTAINS = 2'd1;
    localparam logic [1:0] CMD_SCAN     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANGE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] start_req;
        logic [IDX_W-1:0] count;
        logic             value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] position;
        logic             error;
    } rsp_t;

    // Operands of the shared word unit.
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [WIDX_W-1:0]    widx;
        logic [IDX_W-1:0]     lo;
        logic [IDX_W-1:0]     hi;
        logic [IDX_W-1:0]     size;
        logic [BIDX_W-1:0]    bpos;
        logic                 value;
    } word_op_t;

    // Results of the shared word unit.
    typedef struct packed {
        logic [WORD_BITS-1:0] new_word;
        logic                 any_match;
        logic [JIDX_W-1:0]    next_miss;
    } word_res_t;

endpackage

/* src/bitmap_range_allocator.sv */
// Bitmap range allocator top level: request sequencer, bitmap store, result register.
// Write/contains walk the words that the range spans; scan steps word by word and past each
// mismatching bit until a run is found or the size is reached. Errors and zero-length requests
// go straight to the result state. One request at a time: req_ready is low while the sequencer
// works, so a new request is taken only once the last result has entered the output register.
// Reset clears every bitmap bit at once and sets size_reg to 1024.
module bitmap_range_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  bra_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output bra_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bra_pkg::IDX_W-1:0]   cfg_data
);

    // Bitmap words, each read by the word unit at the walk index.
    logic [bra_pkg::WORD_BITS-1:0] bitmap_reg [bra_pkg::NUM_WORDS];

    bra_pkg::state_t state_reg, state_next;

    logic [bra_pkg::IDX_W-1:0]  size_reg;
    logic [bra_pkg::IDX_W-1:0]  size_eff;

    // Latched request.
    logic [1:0]                 cmd_reg, cmd_next;
    logic [bra_pkg::IDX_W-1:0]  lo_reg, lo_next;
    logic [bra_pkg::IDX_W-1:0]  hi_reg, hi_next;
    logic [bra_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic                       val_reg, val_next;

    // Walk position: word, bit within word, current run length.
    logic [bra_pkg::WIDX_W-1:0] w_reg, w_next;
    logic [bra_pkg::BIDX_W-1:0] p_reg, p_next;
    logic [bra_pkg::IDX_W-1:0]  run_reg, run_next;

    // Result being built, and the output register.
    logic                       hit_reg, hit_next;
    logic [bra_pkg::IDX_W-1:0]  pos_reg, pos_next;
    logic                       err_reg, err_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    bra_pkg::rsp_t              rsp_reg, rsp_next;

    logic                       wr_en;
    logic                       accept;

    bra_pkg::word_op_t          wop;
    bra_pkg::word_res_t         wres;

    // Scan arithmetic.
    logic [bra_pkg::IDX_W:0]    req_end;
    logic [bra_pkg::IDX_W:0]    avail;
    logic [bra_pkg::IDX_W-1:0]  wbase;
    logic [bra_pkg::IDX_W-1:0]  nxt_idx;
    logic [bra_pkg::IDX_W-1:0]  last_idx;
    logic [bra_pkg::JIDX_W-1:0] step;

    assign size_eff  = (size_reg > bra_pkg::SIZE_MAX) ? bra_pkg::SIZE_MAX : size_reg;
    assign req_ready = (state_reg == bra_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_end   = {1'b0, req.start_req} + {1'b0, req.count};

    // One shared word unit serves range writes, contains tests and scan steps.
    assign wop.word  = bitmap_reg[w_reg];
    assign wop.widx  = w_reg;
    assign wop.lo    = lo_reg;
    assign wop.hi    = hi_reg;
    assign wop.size  = size_eff;
    assign wop.bpos  = p_reg;
    assign wop.value = val_reg;

    bra_word_unit u_word (
        .op  (wop),
        .res (wres)
    );

    // avail: run length if every bit from p up to the next mismatch matches.
    assign avail    = {1'b0, run_reg} + (bra_pkg::IDX_W+1)'(wres.next_miss)
                    - (bra_pkg::IDX_W+1)'(p_reg);
    assign wbase    = {1'b0, w_reg, {bra_pkg::BIDX_W{1'b0}}};
    assign step     = wres.next_miss[bra_pkg::BIDX_W]
                    ? bra_pkg::JIDX_W'(bra_pkg::WORD_BITS)
                    : wres.next_miss + bra_pkg::JIDX_W'(1);
    assign nxt_idx  = wbase + bra_pkg::IDX_W'(step);
    assign last_idx = hi_reg - bra_pkg::IDX_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        w_next         = w_reg;
        p_next         = p_reg;
        run_next       = run_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        err_next       = err_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr_en          = 1'b0;

        case (state_reg)
            bra_pkg::ST_IDLE:
            begin
                if (accept) begin
                    cmd_next = req.cmd;
                    lo_next  = req.start_req;
                    hi_next  = req_end[bra_pkg::IDX_W-1:0];
                    cnt_next = req.count;
                    val_next = req.value;
                    w_next   = req.start_req[bra_pkg::BIDX_W +: bra_pkg::WIDX_W];
                    p_next   = req.start_req[bra_pkg::BIDX_W-1:0];
                    run_next = '0;
                    hit_next = 1'b0;
                    pos_next = '0;
                    err_next = 1'b0;
                    // Same bound for all three kinds: start + count within the size.
                    if (!(req.cmd inside {bra_pkg::CMD_WRITE, bra_pkg::CMD_CONTAINS,
                                          bra_pkg::CMD_SCAN})) begin
                        err_next   = 1'b1;
                        state_next = bra_pkg::ST_DONE;
                    end
                    else if (req_end > {1'b0, size_eff}) begin
                        err_next   = 1'b1;
                        state_next = bra_pkg::ST_DONE;
                    end
                    else if (req.count == '0) begin
                        if (req.cmd == bra_pkg::CMD_SCAN) begin
                            hit_next = 1'b1;
                            pos_next = req.start_req;
                        end
                        state_next = bra_pkg::ST_DONE;
                    end
                    else if (req.cmd == bra_pkg::CMD_SCAN) begin
                        state_next = bra_pkg::ST_SCAN;
                    end
                    else begin
                        state_next = bra_pkg::ST_RANGE;
                    end
                end
            end

            bra_pkg::ST_RANGE:
            begin
                if (cmd_reg == bra_pkg::CMD_WRITE) begin
                    wr_en = 1'b1;
                end
                else if (wres.any_match) begin
                    hit_next = 1'b1;
                end
                if (w_reg == last_idx[bra_pkg::BIDX_W +: bra_pkg::WIDX_W]) begin
                    state_next = bra_pkg::ST_DONE;
                end
                else begin
                    w_next = w_reg + bra_pkg::WIDX_W'(1);
                end
            end

            bra_pkg::ST_SCAN:
            begin
                if (avail >= {1'b0, cnt_reg}) begin
                    hit_next   = 1'b1;
                    pos_next   = (wbase | bra_pkg::IDX_W'(p_reg)) - run_reg;
                    state_next = bra_pkg::ST_DONE;
                end
                else if (nxt_idx >= size_eff) begin
                    err_next   = 1'b1;
                    state_next = bra_pkg::ST_DONE;
                end
                else begin
                    w_next = nxt_idx[bra_pkg::BIDX_W +: bra_pkg::WIDX_W];
                    p_next = nxt_idx[bra_pkg::BIDX_W-1:0];
                    if (wres.next_miss[bra_pkg::BIDX_W]) begin
                        run_next = avail[bra_pkg::IDX_W-1:0];
                    end
                    else begin
                        run_next = '0;
                    end
                end
            end

            bra_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready) begin
                    rsp_next.hit      = hit_reg;
                    rsp_next.position = pos_reg;
                    rsp_next.error    = err_reg;
                    rsp_valid_next    = 1'b1;
                    state_next        = bra_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bra_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= bra_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            size_reg      <= bra_pkg::SIZE_MAX;
        end
        else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        w_reg   <= w_next;
        p_reg   <= p_next;
        run_reg <= run_next;
        hit_reg <= hit_next;
        pos_reg <= pos_next;
        err_reg <= err_next;
        rsp_reg <= rsp_next;
    end

    // Bitmap: cleared by reset, one word merged per write beat of the walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < bra_pkg::NUM_WORDS; i++) begin
                bitmap_reg[i] <= '0;
            end
        end
        else if (wr_en) begin
            bitmap_reg[w_reg] <= wres.new_word;
        end
    end

    // A result never claims both a hit and an error.
    a_hit_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.error))
        else $error("result with both hit and error");

    // Only a successful scan reports a nonzero position.
    a_pos_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.position != '0) |-> rsp.hit)
        else $error("position set without hit");

    // While scanning, the open run is always shorter than the run sought.
    a_run_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bra_pkg::ST_SCAN) |-> (run_reg < cnt_reg))
        else $error("scan run reached count without finishing");

    // The bitmap is only written by a write request walk.
    a_write_only_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == bra_pkg::ST_RANGE && cmd_reg == bra_pkg::CMD_WRITE))
        else $error("bitmap written outside a range write");

endmodule

/* src/bra_word_unit.sv */
// Per-word mask, write merge, match test and next-mismatch search.
module bra_word_unit (
    input  bra_pkg::word_op_t  op,
    output bra_pkg::word_res_t res
);

    // Bits of word widx whose absolute index is below limit.
    function automatic logic [bra_pkg::WORD_BITS-1:0] below_mask(
        input logic [bra_pkg::IDX_W-1:0]  limit,
        input logic [bra_pkg::WIDX_W-1:0] widx
    );
        logic [bra_pkg::IDX_W-bra_pkg::BIDX_W-1:0] lw;
        logic [bra_pkg::WORD_BITS-1:0]             m;
        lw = limit[bra_pkg::IDX_W-1:bra_pkg::BIDX_W];
        if (lw > (bra_pkg::IDX_W-bra_pkg::BIDX_W)'(widx)) begin
            m = '1;
        end
        else if (lw == (bra_pkg::IDX_W-bra_pkg::BIDX_W)'(widx)) begin
            m = ~({bra_pkg::WORD_BITS{1'b1}} << limit[bra_pkg::BIDX_W-1:0]);
        end
        else begin
            m = '0;
        end
        return m;
    endfunction

    logic [bra_pkg::WORD_BITS-1:0]  range_mask;
    logic [bra_pkg::WORD_BITS-1:0]  eq_bits;
    logic [bra_pkg::WORD_BITS-1:0]  miss_bits;
    logic [bra_pkg::JIDX_W-1:0]     first_miss;

    assign range_mask = below_mask(op.hi, op.widx) & ~below_mask(op.lo, op.widx);
    assign eq_bits    = ~(op.word ^ {bra_pkg::WORD_BITS{op.value}});

    // Mismatches at or above bpos; bits past the size count as mismatches.
    assign miss_bits  = (~eq_bits | ~below_mask(op.size, op.widx))
                      & ({bra_pkg::WORD_BITS{1'b1}} << op.bpos);

    always_comb
    begin
        first_miss = bra_pkg::JIDX_W'(bra_pkg::WORD_BITS);
        for (int k = bra_pkg::WORD_BITS - 1; k >= 0; k--) begin
            if (miss_bits[k]) begin
                first_miss = bra_pkg::JIDX_W'(k);
            end
        end
    end

    assign res.new_word  = op.value ? (op.word | range_mask) : (op.word & ~range_mask);
    assign res.any_match = |(eq_bits & range_mask);
    assign res.next_miss = first_miss;

endmodule
